### design/least_busy_channel_select_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the least busy channel selector
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LEAST_BUSY_CHANNEL_SELECT_MACROS_SVH
`define LEAST_BUSY_CHANNEL_SELECT_MACROS_SVH

`ifndef SYNTHESIS
`define LBCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LBCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/lbcs_pkg.sv
// ----------------------------------------------------------------------------
// Least busy channel selector package
// Shared types, widths and the fractional power-of-two table.
// ----------------------------------------------------------------------------
package lbcs_pkg;

    localparam int LOAD_W   = 32;
    localparam int SUM_W    = 34;
    localparam int CH_W     = 4;
    localparam int RSSI_W   = 8;
    localparam int SEC_W    = 2;
    localparam int CTR_W    = 6;
    localparam int TAB_W    = 17;
    localparam int TAB_FRAC = 16;
    localparam int Q_W      = 5;
    localparam int F_W      = 4;

    // Reciprocal of ten for values below 256: q = (e * 205) >> 11.
    localparam logic [7:0] Q_MULT  = 8'd205;
    localparam int         Q_SHIFT = 11;

    localparam logic [SEC_W-1:0] SEC_NONE  = 2'd0;
    localparam logic [SEC_W-1:0] SEC_ABOVE = 2'd1;
    localparam logic [SEC_W-1:0] SEC_BELOW = 2'd2;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    // round(2^(f/10) * 2^16)
    localparam logic [TAB_W-1:0] FRAC_TAB [10] = '{
        17'd65536, 17'd70240, 17'd75281, 17'd80684, 17'd86475,
        17'd92682, 17'd99334, 17'd106464, 17'd114105, 17'd122295
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_ADD,
        ST_SUM,
        ST_SCAN,
        ST_DONE
    } lbcs_state_t;

    typedef struct packed {
        logic add_en;
        logic sum_en;
        logic scan_en;
    } lbcs_cell_ctrl_t;

endpackage

### design/least_busy_channel_select.sv
// A record item is captured, then weighted, then added into the cells.
// A select item forms the neighbour sums, then carries the running minimum
// along the cell row, and then loads the output register.
// Throughput: one item at a time (in_stall is high until the item is done); a
// select waits longer while a waiting result is stalled.
// Reset: rst_n clears all channel loads to zero and the control state at once.
module least_busy_channel_select
    import lbcs_pkg::*;
#(
    parameter int NUM_CHANNELS = 13,
    parameter int FRAC_BITS    = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     operation,
    input  logic [CH_W-1:0]          primary_channel,
    input  logic signed [RSSI_W-1:0] signal_strength,
    input  logic [SEC_W-1:0]         secondary_position,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CH_W-1:0]          chosen_channel
);

    `include "least_busy_channel_select_macros.svh"

    localparam int CNT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CHANNELS - 1);

    lbcs_state_t state_reg;
    lbcs_state_t state_next;

    logic                     in_accept;
    logic                     out_free;
    logic                     scan_last;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [CH_W-1:0]          prim_reg;
    logic [SEC_W-1:0]         sec_reg;
    logic signed [RSSI_W-1:0] strength_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [CH_W-1:0]          chosen_reg;
    logic [CH_W-1:0]          chosen_next;
    logic                     weight_en;
    lbcs_cell_ctrl_t          cell_ctrl;
    logic [LOAD_W-1:0]        weight;
    logic signed [CTR_W-1:0]  prim_centre;
    logic signed [CTR_W-1:0]  sec_centre;
    logic                     sec_en;
    logic                     loads_zero;

    logic [LOAD_W-1:0] load_vec     [NUM_CHANNELS];
    logic [SUM_W-1:0]  best_sum_vec [NUM_CHANNELS];
    logic [CH_W-1:0]   best_idx_vec [NUM_CHANNELS];

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_last = (cnt_reg == CNT_LAST);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (operation == OP_SELECT) ? ST_SUM : ST_WEIGHT;
                end
            end
            ST_WEIGHT: state_next = ST_ADD;
            ST_ADD:    state_next = ST_IDLE;
            ST_SUM:    state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        in_stall          = 1'b1;
        weight_en         = 1'b0;
        cell_ctrl.add_en  = 1'b0;
        cell_ctrl.sum_en  = 1'b0;
        cell_ctrl.scan_en = 1'b0;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg && out_stall;
        chosen_next       = chosen_reg;
        case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_WEIGHT: weight_en = 1'b1;
            ST_ADD:    cell_ctrl.add_en = 1'b1;
            ST_SUM:
            begin
                cell_ctrl.sum_en = 1'b1;
                cnt_next         = '0;
            end
            ST_SCAN:
            begin
                cell_ctrl.scan_en = 1'b1;
                cnt_next          = cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    chosen_next    = best_idx_vec[NUM_CHANNELS-1];
                end
            end
            default:   in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prim_reg     <= primary_channel;
            sec_reg      <= secondary_position;
            strength_reg <= signal_strength;
        end
        chosen_reg <= chosen_next;
    end

    always_comb
    begin
        prim_centre = CTR_W'(prim_reg);
        sec_en      = (sec_reg == SEC_ABOVE) || (sec_reg == SEC_BELOW);
        sec_centre  = (sec_reg == SEC_ABOVE) ? prim_centre + CTR_W'(4)
                                             : prim_centre - CTR_W'(4);
    end

    lbcs_weight #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weight (
        .clk      (clk),
        .en       (weight_en),
        .strength (strength_reg),
        .weight   (weight)
    );

    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_cell
        logic [LOAD_W-1:0] left_load;
        logic [LOAD_W-1:0] right_load;
        logic [SUM_W-1:0]  left_sum;
        logic [CH_W-1:0]   left_idx;

        if (i == 0)
        begin : g_first
            assign left_load = '0;
            assign left_sum  = '0;
            assign left_idx  = '0;
        end
        else
        begin : g_inner
            assign left_load = load_vec[i-1];
            assign left_sum  = best_sum_vec[i-1];
            assign left_idx  = best_idx_vec[i-1];
        end

        if (i == NUM_CHANNELS - 1)
        begin : g_last
            assign right_load = '0;
        end
        else
        begin : g_mid
            assign right_load = load_vec[i+1];
        end

        lbcs_cell #(
            .CHANNEL (i + 1)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (cell_ctrl),
            .weight        (weight),
            .prim_centre   (prim_centre),
            .sec_centre    (sec_centre),
            .sec_en        (sec_en),
            .left_load     (left_load),
            .right_load    (right_load),
            .left_best_sum (left_sum),
            .left_best_idx (left_idx),
            .load          (load_vec[i]),
            .best_sum      (best_sum_vec[i]),
            .best_idx      (best_idx_vec[i])
        );
    end

    always_comb
    begin
        loads_zero = 1'b1;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            if (load_vec[k] != '0)
            begin
                loads_zero = 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign chosen_channel = chosen_reg;

    // A select item clears every channel load once the sums are formed.
    `LBCS_ASSERT_NEXT(a_clear_after_sum, clk, rst_n, state_reg == ST_SUM, loads_zero,
        "loads not cleared after select")
    // A new result only appears when the search has finished.
    `LBCS_ASSERT_NOW(a_result_from_done, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == ST_DONE, "result without finished search")
    // The chosen channel is always a real channel.
    `LBCS_ASSERT_NOW(a_channel_range, clk, rst_n, out_valid_reg,
        (chosen_reg >= CH_W'(1)) && (chosen_reg <= CH_W'(NUM_CHANNELS)),
        "chosen channel out of range")
    // An accepted select item starts the neighbour sum step.
    `LBCS_ASSERT_NEXT(a_select_starts, clk, rst_n, in_accept && (operation == OP_SELECT),
        state_reg == ST_SUM, "select did not start")

endmodule

### design/lbcs_weight.sv
// ----------------------------------------------------------------------------
// Record weight unit
// Registers 2^((128+rssi)/10) in unsigned fixed point, saturated to 32 bits.
// ----------------------------------------------------------------------------
module lbcs_weight
    import lbcs_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [RSSI_W-1:0] strength,
    output logic        [LOAD_W-1:0] weight
);

    localparam int MANT_W = FRAC_BITS + 2;

    logic [RSSI_W-1:0]     e;
    logic [15:0]           q_prod;
    logic [Q_W-1:0]        q;
    logic [RSSI_W-1:0]     q_times_ten;
    logic [F_W-1:0]        f;
    logic [TAB_W:0]        rounded;
    logic [MANT_W-1:0]     mant;
    logic [2*LOAD_W-1:0]   wide;
    logic [LOAD_W-1:0]     weight_next;
    logic [LOAD_W-1:0]     weight_reg;

    always_comb
    begin
        // Offset binary: adding 128 flips the sign bit.
        e           = {~strength[RSSI_W-1], strength[RSSI_W-2:0]};
        q_prod      = 16'(e) * 16'(Q_MULT);
        q           = Q_W'(q_prod >> Q_SHIFT);
        q_times_ten = RSSI_W'(q) * RSSI_W'(10);
        f           = F_W'(e - q_times_ten);
        rounded     = {1'b0, FRAC_TAB[f]} + ((TAB_W+1)'(1) << (TAB_FRAC - 1 - FRAC_BITS));
        mant        = MANT_W'(rounded >> (TAB_FRAC - FRAC_BITS));
        wide        = (2*LOAD_W)'(mant) << q;
        weight_next = (|wide[2*LOAD_W-1:LOAD_W]) ? {LOAD_W{1'b1}} : wide[LOAD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule

### design/lbcs_cell.sv
// ----------------------------------------------------------------------------
// Channel cell
// Holds one channel's load, adds record weights, and takes part in the
// minimum-search wave that runs from the lowest channel to the highest.
// ----------------------------------------------------------------------------
module lbcs_cell
    import lbcs_pkg::*;
#(
    parameter int CHANNEL = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lbcs_cell_ctrl_t         ctrl,
    input  logic [LOAD_W-1:0]       weight,
    input  logic signed [CTR_W-1:0] prim_centre,
    input  logic signed [CTR_W-1:0] sec_centre,
    input  logic                    sec_en,
    input  logic [LOAD_W-1:0]       left_load,
    input  logic [LOAD_W-1:0]       right_load,
    input  logic [SUM_W-1:0]        left_best_sum,
    input  logic [CH_W-1:0]         left_best_idx,
    output logic [LOAD_W-1:0]       load,
    output logic [SUM_W-1:0]        best_sum,
    output logic [CH_W-1:0]         best_idx
);

    localparam logic signed [CTR_W-1:0] CH_POS = CTR_W'(CHANNEL);
    localparam logic [CH_W-1:0]         CH_IDX = CH_W'(CHANNEL);
    localparam logic                    FIRST  = (CHANNEL == 1);

    logic [LOAD_W-1:0]       load_reg;
    logic [LOAD_W-1:0]       load_next;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [SUM_W-1:0]        best_sum_reg;
    logic [SUM_W-1:0]        best_sum_next;
    logic [CH_W-1:0]         best_idx_reg;
    logic [CH_W-1:0]         best_idx_next;
    logic signed [CTR_W-1:0] d_prim;
    logic signed [CTR_W-1:0] d_sec;
    logic [LOAD_W-1:0]       amt_prim;
    logic [LOAD_W-1:0]       amt_sec;
    logic [SUM_W-1:0]        total;

    always_comb
    begin
        d_prim = CH_POS - prim_centre;
        d_sec  = CH_POS - sec_centre;

        amt_prim = '0;
        if (d_prim inside {-6'sd1, 6'sd0, 6'sd1})
        begin
            amt_prim = weight;
        end
        else if (d_prim inside {-6'sd2, 6'sd2})
        begin
            amt_prim = weight >> 1;
        end

        amt_sec = '0;
        if (sec_en && (d_sec inside {-6'sd1, 6'sd0, 6'sd1}))
        begin
            amt_sec = weight;
        end
        else if (sec_en && (d_sec inside {-6'sd2, 6'sd2}))
        begin
            amt_sec = weight >> 1;
        end

        // Clamping once after both adds equals clamping after each one.
        total = SUM_W'(load_reg) + SUM_W'(amt_prim) + SUM_W'(amt_sec);

        load_next = load_reg;
        if (ctrl.sum_en)
        begin
            load_next = '0;
        end
        else if (ctrl.add_en)
        begin
            load_next = (|total[SUM_W-1:LOAD_W]) ? {LOAD_W{1'b1}} : total[LOAD_W-1:0];
        end

        sum_next = sum_reg;
        if (ctrl.sum_en)
        begin
            sum_next = SUM_W'(left_load) + SUM_W'(load_reg) + SUM_W'(right_load);
        end

        best_sum_next = best_sum_reg;
        best_idx_next = best_idx_reg;
        if (ctrl.scan_en)
        begin
            // Ties keep the lower channel coming from the left.
            if (FIRST || (sum_reg < left_best_sum))
            begin
                best_sum_next = sum_reg;
                best_idx_next = CH_IDX;
            end
            else
            begin
                best_sum_next = left_best_sum;
                best_idx_next = left_best_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
        end
        else
        begin
            load_reg <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        best_sum_reg <= best_sum_next;
        best_idx_reg <= best_idx_next;
    end

    assign load     = load_reg;
    assign best_sum = best_sum_reg;
    assign best_idx = best_idx_reg;

endmodule

### tb/tb_least_busy_channel_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the least busy channel selector
// Feeds scan records and select requests through the valid/stall handshake,
// predicts the chosen channel from a shadow copy of the per-channel load, and
// compares every result as the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_least_busy_channel_select;
    import lbcs_pkg::*;

    localparam int CHANNELS      = 13;
    localparam int FRAC          = 8;
    localparam int RANDOM_ITEMS  = 1480;
    localparam int LONG_HOLD     = 300;
    localparam logic [LOAD_W-1:0] LOAD_SAT = '1;
    localparam logic [CH_W-1:0]   NO_FIXED = 4'd0;

    // 2^(f/10) in unsigned Q.16.
    localparam int unsigned POW_FRAC [10] = '{
        65536, 70240, 75281, 80684, 86475, 92682, 99334, 106464, 114105, 122295
    };

    typedef struct packed {
        logic                     op;
        logic [CH_W-1:0]          chan;
        logic signed [RSSI_W-1:0] rssi;
        logic [SEC_W-1:0]         sec;
        logic [CH_W-1:0]          fixed_choice;
    } scan_row_t;

    localparam int DIR_ROWS = 21;
    localparam scan_row_t DIRECTED [DIR_ROWS] = '{
        // Empty store selects channel 1.
        '{OP_SELECT, 4'd0,  8'sh00, SEC_NONE,  4'd1},
        // Weakest record on channel 1 leaves channels 4..6 empty.
        '{OP_RECORD, 4'd1,  8'sh80, SEC_NONE,  NO_FIXED},
        '{OP_SELECT, 4'd15, 8'sh7F, 2'd3,      4'd5},
        '{OP_SELECT, 4'd9,  8'shFF, SEC_ABOVE, 4'd1},
        // Out-of-range primaries, the unused secondary code, positive strength.
        '{OP_RECORD, 4'd15, 8'sh7F, SEC_BELOW, NO_FIXED},
        '{OP_RECORD, 4'd0,  8'sh00, SEC_ABOVE, NO_FIXED},
        '{OP_RECORD, 4'd14, 8'shFF, 2'd3,      NO_FIXED},
        '{OP_RECORD, 4'd7,  8'sh01, SEC_ABOVE, NO_FIXED},
        '{OP_SELECT, 4'd5,  8'sh80, SEC_BELOW, NO_FIXED},
        '{OP_RECORD, 4'd13, 8'sh80, SEC_BELOW, NO_FIXED},
        '{OP_RECORD, 4'd1,  8'sh7F, SEC_ABOVE, NO_FIXED},
        '{OP_RECORD, 4'd8,  8'shC4, SEC_NONE,  NO_FIXED},
        '{OP_RECORD, 4'd2,  8'sh9C, SEC_BELOW, NO_FIXED},
        '{OP_SELECT, 4'd10, 8'sh55, SEC_NONE,  NO_FIXED},
        // Saturating weights on every channel, some added twice.
        '{OP_RECORD, 4'd2,  8'sh7F, SEC_ABOVE, NO_FIXED},
        '{OP_RECORD, 4'd6,  8'sh7F, SEC_NONE,  NO_FIXED},
        '{OP_RECORD, 4'd10, 8'sh7F, SEC_ABOVE, NO_FIXED},
        '{OP_RECORD, 4'd12, 8'sh7F, SEC_NONE,  NO_FIXED},
        '{OP_RECORD, 4'd12, 8'sh7F, SEC_ABOVE, NO_FIXED},
        '{OP_SELECT, 4'd3,  8'sh7F, SEC_ABOVE, NO_FIXED},
        '{OP_SELECT, 4'd12, 8'sh80, 2'd3,      4'd1}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     operation;
    logic [CH_W-1:0]          primary_channel;
    logic signed [RSSI_W-1:0] signal_strength;
    logic [SEC_W-1:0]         secondary_position;
    logic                     out_valid;
    logic                     out_stall;
    logic [CH_W-1:0]          chosen_channel;

    logic [LOAD_W-1:0] shadow_load [CHANNELS];
    logic [CH_W-1:0]   choice_q [$];

    int  mismatch_count = 0;
    int  record_count   = 0;
    int  select_count   = 0;
    int  checked_count  = 0;
    int  hold_count     = 0;
    int  drain_count    = 0;
    int  burst_left     = 0;
    bit  sender_idles   = 1'b1;
    bit  hold_req       = 1'b0;

    least_busy_channel_select #(
        .NUM_CHANNELS (CHANNELS),
        .FRAC_BITS    (FRAC)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .operation          (operation),
        .primary_channel    (primary_channel),
        .signal_strength    (signal_strength),
        .secondary_position (secondary_position),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .chosen_channel     (chosen_channel)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Weight of one record: 2^((128 + rssi) / 10) with FRAC fractional bits.
    function automatic logic [LOAD_W-1:0] record_weight(logic signed [RSSI_W-1:0] rs);
        int          e;
        int          q;
        int          f;
        logic [63:0] m;
        logic [63:0] w;
        e = 128 + int'(rs);
        q = e / 10;
        f = e % 10;
        m = (64'(POW_FRAC[f]) + (64'd1 << (15 - FRAC))) >> (16 - FRAC);
        w = m << q;
        return (w > 64'(LOAD_SAT)) ? LOAD_SAT : w[LOAD_W-1:0];
    endfunction

    function automatic void load_add(int ch, logic [LOAD_W-1:0] amount);
        logic [LOAD_W:0] v;
        if (ch < 1 || ch > CHANNELS)
            return;
        v = {1'b0, shadow_load[ch-1]} + {1'b0, amount};
        shadow_load[ch-1] = v[LOAD_W] ? LOAD_SAT : v[LOAD_W-1:0];
    endfunction

    function automatic void spread_load(int centre, logic [LOAD_W-1:0] w);
        for (int d = -2; d <= 2; d++)
            load_add(centre + d, (d == 2 || d == -2) ? (w >> 1) : w);
    endfunction

    function automatic void add_scan_record(logic [CH_W-1:0] ch,
                                            logic signed [RSSI_W-1:0] rs,
                                            logic [SEC_W-1:0] sec);
        logic [LOAD_W-1:0] w;
        w = record_weight(rs);
        spread_load(int'(ch), w);
        if (sec == SEC_ABOVE)
            spread_load(int'(ch) + 4, w);
        else if (sec == SEC_BELOW)
            spread_load(int'(ch) - 4, w);
    endfunction

    // Lowest channel with the smallest neighbour-smeared load; clears the store.
    function automatic logic [CH_W-1:0] least_loaded_channel();
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] best_sum;
        int               best;
        best     = 1;
        best_sum = '0;
        for (int i = 1; i <= CHANNELS; i++)
        begin
            sum = SUM_W'(shadow_load[i-1]);
            if (i > 1)
                sum += SUM_W'(shadow_load[i-2]);
            if (i < CHANNELS)
                sum += SUM_W'(shadow_load[i]);
            if (i == 1 || sum < best_sum)
            begin
                best_sum = sum;
                best     = i;
            end
        end
        foreach (shadow_load[k])
            shadow_load[k] = '0;
        return CH_W'(best);
    endfunction

    // Presents one item and returns once it has been taken.
    task automatic offer(logic op, logic [CH_W-1:0] ch, logic signed [RSSI_W-1:0] rs,
                         logic [SEC_W-1:0] sec, logic [CH_W-1:0] fixed_choice);
        int              gap;
        logic [CH_W-1:0] expected;
        gap = 0;
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid           <= 1'b1;
        operation          <= op;
        primary_channel    <= ch;
        signal_strength    <= rs;
        secondary_position <= sec;
        do
            @(posedge clk);
        while (in_stall);
        if (op == OP_RECORD)
        begin
            add_scan_record(ch, rs, sec);
            record_count++;
        end
        else
        begin
            expected = least_loaded_channel();
            if (fixed_choice != NO_FIXED)
                expected = fixed_choice;
            choice_q = {choice_q, expected};
            select_count++;
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (choice_q.size() != 0)
            @(posedge clk);
        drain_count++;
    endtask

    // Receiver: random stall patterns, plus a long hold-off on request.
    initial
    begin
        int len;
        int mode;
        out_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_count++;
                for (int i = 0; i < LONG_HOLD; i++)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                len  = $urandom_range(5, 60);
                mode = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                begin
                    @(negedge clk);
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= i[0];
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (choice_q.size() == 0)
                report_mismatch("chosen_channel with no select pending",
                                int'(chosen_channel), 0);
            else
            begin
                logic [CH_W-1:0] want;
                want = choice_q.pop_front();
                if (chosen_channel !== want)
                    report_mismatch("chosen_channel", int'(chosen_channel), int'(want));
                checked_count++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: run did not finish, %0d results outstanding", choice_q.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int                       n_records;
        int                       sent;
        logic [CH_W-1:0]          ch;
        logic signed [RSSI_W-1:0] rs;
        logic [SEC_W-1:0]         sec;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        operation          = OP_RECORD;
        primary_channel    = '0;
        signal_strength    = '0;
        secondary_position = SEC_NONE;
        foreach (shadow_load[k])
            shadow_load[k] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[r])
            offer(DIRECTED[r].op, DIRECTED[r].chan, DIRECTED[r].rssi,
                  DIRECTED[r].sec, DIRECTED[r].fixed_choice);
        wait_for_results();

        // Random part: bursts of scan records closed by a select.
        hold_req = 1'b1;
        sent     = 0;
        while (sent < RANDOM_ITEMS)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            n_records    = $urandom_range(0, 10);
            for (int i = 0; i < n_records; i++)
            begin
                ch = ($urandom_range(0, 5) == 0) ? CH_W'($urandom_range(0, 15))
                                                 : CH_W'($urandom_range(1, CHANNELS));
                case ($urandom_range(0, 9))
                    0, 1:    rs = RSSI_W'($urandom_range(0, 255));
                    2:       rs = RSSI_W'($urandom_range(80, 127));
                    default: rs = RSSI_W'(256 - $urandom_range(20, 100));
                endcase
                sec = SEC_W'($urandom_range(0, 3));
                offer(OP_RECORD, ch, rs, sec, NO_FIXED);
            end
            offer(OP_SELECT, CH_W'($urandom_range(0, 15)), RSSI_W'($urandom_range(0, 255)),
                  SEC_W'($urandom_range(0, 3)), NO_FIXED);
            sent += n_records + 1;
            if ($urandom_range(0, 59) == 0)
                hold_req = 1'b1;
            if ($urandom_range(0, 29) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (CHANNELS + 8) @(posedge clk);

        $display("Covered %0d scan records and %0d selects, %0d chosen channels checked.",
                 record_count, select_count, checked_count);
        $display("Receiver held off %0d times; sender waited for an empty pipe %0d times.",
                 hold_count, drain_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
